// ===== hw/rtl/tfa_pkg.sv =====
// -----------------------------------------------------------------------------
// tfa_pkg
// Types, codes and constants shared by the temperature frame alarm modules.
// -----------------------------------------------------------------------------
package tfa_pkg;

  localparam int unsigned TempW   = 15;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 8;
  localparam int unsigned MaskW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ByteW-1:0] HeadFirst  = 8'hA5;
  localparam logic [ByteW-1:0] HeadSecond = 8'h5A;
  localparam logic [ByteW-1:0] FrameTail  = 8'h1A;
  localparam logic [ByteW-1:0] StatusLow  = 8'h03;
  localparam logic [ByteW-1:0] FrameBytes = 8'd8;
  localparam logic [TempW-1:0] HundredsScale = 15'd100;
  localparam logic [CountW-1:0] CountMax = 8'hFF;

  localparam logic [TempW-1:0] LowLimitRst   = 15'd20;
  localparam logic [TempW-1:0] HighLimitRst  = 15'd80;
  localparam logic [TempW-1:0] ValidLimitRst = 15'd1000;
  localparam logic [CountW-1:0] RunLengthRst = 8'd10;
  localparam logic [MaskW-1:0] LowMaskRst    = 32'd3600;
  localparam logic [MaskW-1:0] HighMaskRst   = 32'd3600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_LIMIT   = 3'd0,
    CFG_HIGH_LIMIT  = 3'd1,
    CFG_VALID_LIMIT = 3'd2,
    CFG_RUN_LENGTH  = 3'd3,
    CFG_LOW_MASK    = 3'd4,
    CFG_HIGH_MASK   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALARM_NONE = 2'd0,
    ALARM_LOW  = 2'd1,
    ALARM_HIGH = 2'd2
  } alarm_e;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  typedef struct packed {
    logic [TempW-1:0]  low_limit;
    logic [TempW-1:0]  high_limit;
    logic [TempW-1:0]  valid_limit;
    logic [CountW-1:0] run_length;
    logic [MaskW-1:0]  low_mask_ticks;
    logic [MaskW-1:0]  high_mask_ticks;
  } cfg_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic             tick;
    logic             fmt_ok;
    logic             in_range;
    logic             status_low;
    logic             is_low;
    logic             is_high;
    logic [TempW-1:0] temp;
  } cmd_t;

  typedef struct packed {
    logic             accepted;
    logic [TempW-1:0] temp;
    alarm_e           alarm;
  } res_t;

endpackage

// ===== hw/rtl/tfa_front.sv =====
// -----------------------------------------------------------------------------
// tfa_front
// Checks frame format, forms the reading and classifies it against the limits.
// -----------------------------------------------------------------------------
module tfa_front (
  input  tfa_pkg::cfg_t              cfg_i,
  input  logic                       action_i,
  input  logic [tfa_pkg::ByteW-1:0]  frame_length_i,
  input  logic [tfa_pkg::ByteW-1:0]  head_first_i,
  input  logic [tfa_pkg::ByteW-1:0]  head_second_i,
  input  logic [tfa_pkg::ByteW-1:0]  temp_hundreds_i,
  input  logic [tfa_pkg::ByteW-1:0]  temp_units_i,
  input  logic [tfa_pkg::ByteW-1:0]  sensor_status_i,
  input  logic [tfa_pkg::ByteW-1:0]  frame_tail_i,
  output tfa_pkg::cmd_t              cmd_o
);
  import tfa_pkg::*;

  logic [TempW-1:0] temp;

  // Max reading 255*100+255 = 25755 fits the 15-bit field.
  assign temp = TempW'(temp_hundreds_i) * HundredsScale + TempW'(temp_units_i);

  always_comb begin
    cmd_o.tick       = (action_i == ACT_TICK);
    cmd_o.fmt_ok     = (frame_length_i == FrameBytes) && (head_first_i == HeadFirst) &&
                       (head_second_i == HeadSecond) && (frame_tail_i == FrameTail);
    cmd_o.in_range   = (temp <= cfg_i.valid_limit);
    cmd_o.status_low = (sensor_status_i == StatusLow);
    cmd_o.is_low     = (temp < cfg_i.low_limit);
    cmd_o.is_high    = (temp > cfg_i.high_limit);
    cmd_o.temp       = temp;
  end

endmodule

// ===== hw/rtl/tfa_cmd_fifo.sv =====
// -----------------------------------------------------------------------------
// tfa_cmd_fifo
// Two-entry queue of classified requests between front and back end.
// -----------------------------------------------------------------------------
module tfa_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  tfa_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          valid_o,
  output tfa_pkg::cmd_t rd_data_o
);
  import tfa_pkg::*;

  cmd_t        mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_wr;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    count_d  = count_q + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/tfa_back.sv =====
// -----------------------------------------------------------------------------
// tfa_back
// Runs the alarm state (run counts, mask timers) and buffers the results.
// -----------------------------------------------------------------------------
module tfa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tfa_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  tfa_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tfa_pkg::res_t res_o
);
  import tfa_pkg::*;

  logic [CountW-1:0] low_cnt_q, low_cnt_d;
  logic [CountW-1:0] high_cnt_q, high_cnt_d;
  logic [MaskW-1:0]  low_mask_q, low_mask_d;
  logic [MaskW-1:0]  high_mask_q, high_mask_d;

  res_t        res_buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_pop;
  res_t        res_new;
  logic        low_done;
  logic [CountW-1:0] low_bump, high_bump;

  assign empty_o    = (count_q == 2'd0);
  assign res_o      = res_buf_q[rd_ptr_q];
  assign do_pop     = pop_i && !empty_o;
  // Take a request whenever the result buffer has room after this edge.
  assign cmd_take_o = cmd_valid_i && ((count_q != 2'd2) || do_pop);

  assign low_bump  = (low_cnt_q == CountMax) ? CountMax : low_cnt_q + 8'd1;
  assign high_bump = (high_cnt_q == CountMax) ? CountMax : high_cnt_q + 8'd1;

  always_comb begin
    low_cnt_d   = low_cnt_q;
    high_cnt_d  = high_cnt_q;
    low_mask_d  = low_mask_q;
    high_mask_d = high_mask_q;
    low_done    = 1'b0;
    res_new.accepted = !cmd_i.tick && cmd_i.fmt_ok && cmd_i.in_range;
    res_new.temp     = (!cmd_i.tick && cmd_i.fmt_ok) ? cmd_i.temp : '0;
    res_new.alarm    = ALARM_NONE;

    if (cmd_i.tick) begin
      if (low_mask_q != '0) begin
        low_mask_d = low_mask_q - 32'd1;
      end
      if (high_mask_q != '0) begin
        high_mask_d = high_mask_q - 32'd1;
      end
    end else if (res_new.accepted) begin
      if (low_mask_q == '0) begin
        if (cmd_i.status_low) begin
          low_mask_d    = cfg_i.low_mask_ticks;
          res_new.alarm = ALARM_LOW;
          low_done      = 1'b1;
        end else if (cmd_i.is_low) begin
          low_cnt_d = low_bump;
          if (low_bump >= cfg_i.run_length) begin
            low_mask_d    = cfg_i.low_mask_ticks;
            res_new.alarm = ALARM_LOW;
            low_done      = 1'b1;
          end
        end else begin
          low_cnt_d = '0;
        end
      end
      // A low alarm ends the step: skip the high check.
      if (!low_done && (high_mask_q == '0)) begin
        if (cmd_i.is_high) begin
          high_cnt_d = high_bump;
          if (high_bump >= cfg_i.run_length) begin
            high_mask_d   = cfg_i.high_mask_ticks;
            res_new.alarm = ALARM_HIGH;
          end
        end else begin
          high_cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cnt_q   <= '0;
      high_cnt_q  <= '0;
      low_mask_q  <= '0;
      high_mask_q <= '0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      count_q     <= 2'd0;
    end else begin
      if (cmd_take_o) begin
        low_cnt_q   <= low_cnt_d;
        high_cnt_q  <= high_cnt_d;
        low_mask_q  <= low_mask_d;
        high_mask_q <= high_mask_d;
      end
      wr_ptr_q <= wr_ptr_q ^ cmd_take_o;
      rd_ptr_q <= rd_ptr_q ^ do_pop;
      count_q  <= count_q + 2'(cmd_take_o) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      res_buf_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

// ===== hw/rtl/temperature_frame_alarm.sv =====
// -----------------------------------------------------------------------------
// temperature_frame_alarm
// Sensor frame checker with low and high temperature alarms and mask timers.
// -----------------------------------------------------------------------------
// Flow: a pushed request is registered in the command queue; the back end
//   resolves the queue head combinationally and registers the result in
//   the result buffer, from which pop takes it. Throughput: one request per
//   cycle while full is low and the result buffer has room or is popped.
// Reset: rst_ni clears queues, run counts and mask timers at once and loads
//   the configuration registers with their defaults; no clearing pass.
// -----------------------------------------------------------------------------
module temperature_frame_alarm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [tfa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tfa_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // request side
  input  logic                          push,
  output logic                          full,
  input  logic                          action_i,
  input  logic [tfa_pkg::ByteW-1:0]     frame_length_i,
  input  logic [tfa_pkg::ByteW-1:0]     head_first_i,
  input  logic [tfa_pkg::ByteW-1:0]     head_second_i,
  input  logic [tfa_pkg::ByteW-1:0]     temp_hundreds_i,
  input  logic [tfa_pkg::ByteW-1:0]     temp_units_i,
  input  logic [tfa_pkg::ByteW-1:0]     sensor_status_i,
  input  logic [tfa_pkg::ByteW-1:0]     frame_tail_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          frame_accepted_o,
  output logic [tfa_pkg::TempW-1:0]     temperature_tenths_o,
  output logic [1:0]                    alarm_code_o
);
  import tfa_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_valid;
  logic back_take;
  res_t res;

  // Configuration registers: write only, unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_LIMIT:   cfg_d.low_limit       = cfg_wdata_i[TempW-1:0];
        CFG_HIGH_LIMIT:  cfg_d.high_limit      = cfg_wdata_i[TempW-1:0];
        CFG_VALID_LIMIT: cfg_d.valid_limit     = cfg_wdata_i[TempW-1:0];
        CFG_RUN_LENGTH:  cfg_d.run_length      = cfg_wdata_i[CountW-1:0];
        CFG_LOW_MASK:    cfg_d.low_mask_ticks  = cfg_wdata_i[MaskW-1:0];
        CFG_HIGH_MASK:   cfg_d.high_mask_ticks = cfg_wdata_i[MaskW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit       <= LowLimitRst;
      cfg_q.high_limit      <= HighLimitRst;
      cfg_q.valid_limit     <= ValidLimitRst;
      cfg_q.run_length      <= RunLengthRst;
      cfg_q.low_mask_ticks  <= LowMaskRst;
      cfg_q.high_mask_ticks <= HighMaskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: format check and limit compares. The user changes configuration
  // only while idle (not enforced here), so classifying at the door is safe.
  tfa_front u_front (
    .cfg_i           (cfg_q),
    .action_i        (action_i),
    .frame_length_i  (frame_length_i),
    .head_first_i    (head_first_i),
    .head_second_i   (head_second_i),
    .temp_hundreds_i (temp_hundreds_i),
    .temp_units_i    (temp_units_i),
    .sensor_status_i (sensor_status_i),
    .frame_tail_i    (frame_tail_i),
    .cmd_o           (front_cmd)
  );

  // Hold classified requests until the back end takes them.
  tfa_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_en_i   (back_take),
    .valid_o   (queue_valid),
    .rd_data_o (queue_cmd)
  );

  // Back end: advance run counts and mask timers, buffer the result.
  tfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_take_o  (back_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign frame_accepted_o     = res.accepted;
  assign temperature_tenths_o = res.temp;
  assign alarm_code_o         = res.alarm;

endmodule

// ===== tb/temperature_frame_alarm_tb.sv =====
// -----------------------------------------------------------------------------
// temperature_frame_alarm_tb
// Self-checking bench for the sensor frame alarm block. A scoreboard class
// predicts every result from its own copy of the registers, run counts and
// mask timers. Directed frames come first, then phases of random requests
// under different register settings and sender/receiver idling patterns.
// -----------------------------------------------------------------------------
module temperature_frame_alarm_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tfa_pkg::*;

  localparam int unsigned MaxReading = 25755;

  // One request as the sender presents it on the ports.
  typedef struct {
    action_e          act;
    logic [ByteW-1:0] frame_len;
    logic [ByteW-1:0] head1;
    logic [ByteW-1:0] head2;
    logic [ByteW-1:0] hundreds;
    logic [ByteW-1:0] units;
    logic [ByteW-1:0] status;
    logic [ByteW-1:0] tail;
  } frame_req_t;

  // Register values and stimulus shape for one phase of the random part.
  typedef struct {
    int unsigned low_lim;
    int unsigned high_lim;
    int unsigned valid_lim;
    int unsigned run_len;
    logic [31:0] low_mask;
    logic [31:0] high_mask;
    int unsigned n_items;
    int unsigned low_bias;
  } phase_plan_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: alarm predictor plus the queue of results still owed.
  // ---------------------------------------------------------------------------
  class alarm_scoreboard;
    logic [TempW-1:0]  low_limit;
    logic [TempW-1:0]  high_limit;
    logic [TempW-1:0]  valid_limit;
    logic [CountW-1:0] run_length;
    logic [MaskW-1:0]  low_mask_ticks;
    logic [MaskW-1:0]  high_mask_ticks;

    logic [CountW-1:0] low_run;
    logic [CountW-1:0] high_run;
    logic [MaskW-1:0]  low_mask_left;
    logic [MaskW-1:0]  high_mask_left;

    res_t        owed_q[$];
    int unsigned mismatches;
    int unsigned n_checked;

    function new();
      low_limit       = LowLimitRst;
      high_limit      = HighLimitRst;
      valid_limit     = ValidLimitRst;
      run_length      = RunLengthRst;
      low_mask_ticks  = LowMaskRst;
      high_mask_ticks = HighMaskRst;
      low_run         = '0;
      high_run        = '0;
      low_mask_left   = '0;
      high_mask_left  = '0;
      mismatches      = 0;
      n_checked       = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_LOW_LIMIT:   low_limit       = data[TempW-1:0];
        CFG_HIGH_LIMIT:  high_limit      = data[TempW-1:0];
        CFG_VALID_LIMIT: valid_limit     = data[TempW-1:0];
        CFG_RUN_LENGTH:  run_length      = data[CountW-1:0];
        CFG_LOW_MASK:    low_mask_ticks  = data[MaskW-1:0];
        CFG_HIGH_MASK:   high_mask_ticks = data[MaskW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the alarm state by one accepted request and queue its result.
    function void note_request(frame_req_t r);
      res_t        res;
      int unsigned reading;
      bit          low_fired;
      res          = '0;
      res.alarm    = ALARM_NONE;
      low_fired    = 1'b0;
      if (r.act == ACT_TICK) begin
        if (low_mask_left != 0) low_mask_left--;
        if (high_mask_left != 0) high_mask_left--;
      end else if (r.frame_len == FrameBytes && r.head1 == HeadFirst &&
                   r.head2 == HeadSecond && r.tail == FrameTail) begin
        reading  = int'(r.hundreds) * 100 + int'(r.units);
        res.temp = reading[TempW-1:0];
        if (reading <= valid_limit) begin
          res.accepted = 1'b1;
          if (low_mask_left == 0) begin
            // Sensor-reported low status alarms at once, run count untouched.
            if (r.status == StatusLow) begin
              low_fired = 1'b1;
            end else if (reading < low_limit) begin
              if (low_run != CountMax) low_run++;
              if (low_run >= run_length) low_fired = 1'b1;
            end else begin
              low_run = '0;
            end
          end
          if (low_fired) begin
            low_mask_left = low_mask_ticks;
            res.alarm     = ALARM_LOW;
          end else if (high_mask_left == 0) begin
            if (reading > high_limit) begin
              if (high_run != CountMax) high_run++;
              if (high_run >= run_length) begin
                high_mask_left = high_mask_ticks;
                res.alarm      = ALARM_HIGH;
              end
            end else begin
              high_run = '0;
            end
          end
        end
      end
      owed_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting (temp %0d)", got.temp));
      end else begin
        want = owed_q.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("result %0d accepted %b, want %b",
                                    n_checked, got.accepted, want.accepted));
        if (got.temp !== want.temp)
          report_mismatch($sformatf("result %0d temperature %0d, want %0d",
                                    n_checked, got.temp, want.temp));
        if (got.alarm !== want.alarm)
          report_mismatch($sformatf("result %0d alarm %0d, want %0d",
                                    n_checked, got.alarm, want.alarm));
      end
      n_checked++;
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic                action_i = 1'b0;
  logic [ByteW-1:0]    frame_length_i = '0;
  logic [ByteW-1:0]    head_first_i = '0;
  logic [ByteW-1:0]    head_second_i = '0;
  logic [ByteW-1:0]    temp_hundreds_i = '0;
  logic [ByteW-1:0]    temp_units_i = '0;
  logic [ByteW-1:0]    sensor_status_i = '0;
  logic [ByteW-1:0]    frame_tail_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic                frame_accepted_o;
  logic [TempW-1:0]    temperature_tenths_o;
  logic [1:0]          alarm_code_o;

  alarm_scoreboard board = new();

  // Idle percentages, changed by the stimulus process between phases.
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;

  temperature_frame_alarm DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .push                 (push),
    .full                 (full),
    .action_i             (action_i),
    .frame_length_i       (frame_length_i),
    .head_first_i         (head_first_i),
    .head_second_i        (head_second_i),
    .temp_hundreds_i      (temp_hundreds_i),
    .temp_units_i         (temp_units_i),
    .sensor_status_i      (sensor_status_i),
    .frame_tail_i         (frame_tail_i),
    .empty                (empty),
    .pop                  (pop),
    .frame_accepted_o     (frame_accepted_o),
    .temperature_tenths_o (temperature_tenths_o),
    .alarm_code_o         (alarm_code_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: stall pop at random according to the current phase.
  initial begin
    forever begin
      @(posedge clk_i);
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Monitor: everything is sampled at the edge where it takes effect, so the
  // values seen here are the ones the block saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) board.write_register(cfg_idx_e'(cfg_idx_i), cfg_wdata_i);
      if (push && !full)
        board.note_request('{act: action_e'(action_i), frame_len: frame_length_i,
                             head1: head_first_i, head2: head_second_i,
                             hundreds: temp_hundreds_i, units: temp_units_i,
                             status: sensor_status_i, tail: frame_tail_i});
      if (pop && !empty)
        board.check_result('{accepted: frame_accepted_o, temp: temperature_tenths_o,
                             alarm: alarm_e'(alarm_code_o)});
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends in the time step of a rising
  // edge, so each drive below lands as one nonblocking update per step.
  // ---------------------------------------------------------------------------
  task automatic write_port(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Hold the request on the ports until the block takes it.
  task automatic send_request(frame_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    action_i        <= r.act;
    frame_length_i  <= r.frame_len;
    head_first_i    <= r.head1;
    head_second_i   <= r.head2;
    temp_hundreds_i <= r.hundreds;
    temp_units_i    <= r.units;
    sensor_status_i <= r.status;
    frame_tail_i    <= r.tail;
    do @(posedge clk_i); while (full);
  endtask

  // Drop push, let the monitor note the last request, then wait for every
  // owed result plus the pipeline depth.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic frame_req_t make_frame(logic [7:0] hundreds, logic [7:0] units,
                                            logic [7:0] status);
    frame_req_t r;
    r = '{act: ACT_FRAME, frame_len: FrameBytes, head1: HeadFirst, head2: HeadSecond,
          hundreds: hundreds, units: units, status: status, tail: FrameTail};
    return r;
  endfunction

  // Well-formed frame carrying reading t; sometimes spill units past 99.
  function automatic frame_req_t reading_frame(int v, logic [7:0] status);
    int unsigned t;
    int unsigned h;
    int unsigned u;
    t = (v < 0) ? 0 : ((v > MaxReading) ? MaxReading : v);
    h = t / 100;
    u = t % 100;
    if (h > 0 && $urandom_range(1) == 1) begin
      h = h - 1;
      u = u + 100;
    end
    // Readings past 25599 need units above 99 to keep hundreds in a byte.
    while (h > 255) begin
      h = h - 1;
      u = u + 100;
    end
    return make_frame(h[7:0], u[7:0], status);
  endfunction

  function automatic logic [7:0] plain_status();
    logic [7:0] s;
    s = 8'($urandom_range(255));
    if (s == StatusLow) s = ~StatusLow;
    return s;
  endfunction

  function automatic frame_req_t random_request(int unsigned low_bias);
    frame_req_t r;
    int unsigned sel;
    int lo;
    int hi;
    int va;
    lo  = int'(board.low_limit);
    hi  = int'(board.high_limit);
    va  = int'(board.valid_limit);
    sel = $urandom_range(99);
    if ($urandom_range(99) < low_bias) begin
      return reading_frame(lo - 1 - $urandom_range(40), plain_status());
    end
    r = make_frame(8'($urandom_range(255)), 8'($urandom_range(255)), plain_status());
    if (sel < 12) begin
      // Tick: the frame fields are noise.
      r = '{act: ACT_TICK, frame_len: 8'($urandom), head1: 8'($urandom),
            head2: 8'($urandom), hundreds: 8'($urandom), units: 8'($urandom),
            status: 8'($urandom), tail: 8'($urandom)};
    end else if (sel < 22) begin
      // Break one or more of the format fields.
      r = reading_frame($urandom_range(MaxReading), plain_status());
      do begin
        case ($urandom_range(3))
          0: r.frame_len = 8'($urandom);
          1: r.head1     = 8'($urandom);
          2: r.head2     = 8'($urandom);
          default: r.tail = 8'($urandom);
        endcase
      end while (r.frame_len == FrameBytes && r.head1 == HeadFirst &&
                 r.head2 == HeadSecond && r.tail == FrameTail);
    end else if (sel < 27) begin
      r = reading_frame(lo + $urandom_range(40) - 20, StatusLow);
    end else if (sel < 32) begin
      // Raw bytes as given: mostly above the valid limit.
    end else if (sel < 37) begin
      r = reading_frame(va + 1 + $urandom_range(200), plain_status());
    end else if (sel < 62) begin
      r = reading_frame(lo - 1 - $urandom_range(40), plain_status());
    end else if (sel < 87) begin
      r = reading_frame(hi + 1 + $urandom_range(40), plain_status());
    end else begin
      case ($urandom_range(2))
        0: r = reading_frame(lo + $urandom_range(6) - 3, plain_status());
        1: r = reading_frame(hi + $urandom_range(6) - 3, plain_status());
        default: r = reading_frame(va + $urandom_range(6) - 3, plain_status());
      endcase
    end
    return r;
  endfunction

  // Phases of the random part: limits at both ends, run length zero, one and
  // the maximum, masks of zero, short and never-expiring.
  phase_plan_t plan [8] = '{
    '{20,    80,    1000,  10,  32'd3600,     32'd3600,     120, 20},
    '{300,   600,   1000,  3,   32'd20,       32'd15,       120, 20},
    '{0,     25755, 25755, 1,   32'd0,        32'd0,        80,  10},
    '{25755, 0,     25755, 1,   32'd5,        32'd5,        120, 10},
    '{100,   0,     0,     0,   32'd2,        32'd2,        80,  20},
    // long low runs to reach the saturated run count
    '{400,   700,   1200,  255, 32'd3,        32'd3,        600, 99},
    '{2000,  2200,  25755, 4,   32'd7,        32'hFFFFFFFF, 100, 20},
    '{1500,  1500,  3000,  2,   32'hFFFFFFFF, 32'd1,        100, 20}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    frame_req_t directed_q[$];
    frame_req_t all_ones;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: short runs and masks so that both alarms fire and expire.
    write_port(CFG_RUN_LENGTH, 32'd2);
    write_port(CFG_LOW_MASK, 32'd2);
    write_port(CFG_HIGH_MASK, 32'd2);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);

    directed_q.push_back(make_frame(8'd0, 8'd50, 8'd0));     // normal reading
    directed_q.push_back(make_frame(8'd0, 8'd50, 8'd0));
    directed_q[$].frame_len = 8'd7;
    directed_q.push_back(make_frame(8'd0, 8'd50, 8'd0));
    directed_q[$].frame_len = 8'd0;
    directed_q.push_back(make_frame(8'd0, 8'd50, 8'd0));
    directed_q[$].frame_len = 8'hFF;
    directed_q.push_back(make_frame(8'd0, 8'd50, 8'd0));
    directed_q[$].head1 = 8'h00;
    directed_q.push_back(make_frame(8'd0, 8'd50, 8'd0));
    directed_q[$].head2 = 8'hFF;
    directed_q.push_back(make_frame(8'd0, 8'd50, 8'd0));
    directed_q[$].tail = 8'h00;
    directed_q.push_back(make_frame(8'hFF, 8'hFF, 8'hFF));   // largest reading
    directed_q.push_back(make_frame(8'd10, 8'd0, 8'd0));     // exactly valid limit
    directed_q.push_back(make_frame(8'd10, 8'd1, 8'd0));     // one above it
    directed_q.push_back(make_frame(8'd0, 8'd50, StatusLow)); // sensor low status
    directed_q.push_back(make_frame(8'd0, 8'd0, 8'd0));      // low but masked
    all_ones = '{act: ACT_TICK, frame_len: '1, head1: '1, head2: '1, hundreds: '1,
                 units: '1, status: '1, tail: '1};
    directed_q.push_back('{act: ACT_TICK, frame_len: '0, head1: '0, head2: '0,
                           hundreds: '0, units: '0, status: '0, tail: '0});
    directed_q.push_back(all_ones);
    directed_q.push_back(make_frame(8'd0, 8'd5, 8'd0));      // low run starts
    directed_q.push_back(make_frame(8'd0, 8'd19, 8'd0));     // low run alarms
    directed_q.push_back(make_frame(8'd0, 8'd90, 8'd0));     // high run starts
    directed_q.push_back(make_frame(8'd2, 8'd0, 8'd0));      // high run alarms
    directed_q.push_back(make_frame(8'd3, 8'd0, 8'd0));      // both masked
    directed_q.push_back(all_ones);
    directed_q.push_back(all_ones);
    directed_q.push_back(make_frame(8'd0, 8'd150, 8'd0));    // held count alarms again
    directed_q.push_back(make_frame(8'd0, 8'd20, 8'd0));     // on the low limit
    directed_q.push_back(make_frame(8'd0, 8'd80, 8'd0));     // on the high limit
    foreach (directed_q[i]) send_request(directed_q[i]);
    drain();

    // Random phases; idling cycles through none, sender, receiver, both.
    foreach (plan[p]) begin
      write_port(CFG_LOW_LIMIT, plan[p].low_lim);
      write_port(CFG_HIGH_LIMIT, plan[p].high_lim);
      write_port(CFG_VALID_LIMIT, plan[p].valid_lim);
      write_port(CFG_RUN_LENGTH, plan[p].run_len);
      write_port(CFG_LOW_MASK, plan[p].low_mask);
      write_port(CFG_HIGH_MASK, plan[p].high_mask);
      cfg_we_i <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 66; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 66; end
        default: begin send_idle_pct = 30; pop_stall_pct = 30; end
      endcase
      @(posedge clk_i);
      repeat (plan[p].n_items) send_request(random_request(plan[p].low_bias));
      drain();
    end

    if (board.owed_q.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.owed_q.size()));
    if (board.mismatches == 0) begin
      $display("temperature_frame_alarm_tb: clean");
    end else begin
      $display("temperature_frame_alarm_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("temperature_frame_alarm_tb: errors");
    $finish;
  end

endmodule
